FILE: src/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Clocked property checks shared by the FSK demodulator RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
	else $error(msg);

// next-cycle implication
`define ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
	else $error(msg);

`endif

FILE: src/fskd_pkg.sv
// ----------------------------------------------------------------------------
// FSK demodulator package
// Shared types, sizes and tone coefficient table.
// ----------------------------------------------------------------------------
package fskd_pkg;

	localparam int HIST_W = 16;
	localparam int SUM_W  = 36;
	localparam int PROD_W = 33;

	typedef struct packed {
		logic signed [SUM_W-1:0] mi;
		logic signed [SUM_W-1:0] mq;
		logic signed [SUM_W-1:0] si;
		logic signed [SUM_W-1:0] sq;
		logic [HIST_W-1:0]       hist;
	} cell_t;

	typedef struct packed {
		logic signed [PROD_W-1:0] mi;
		logic signed [PROD_W-1:0] mq;
		logic signed [PROD_W-1:0] si;
		logic signed [PROD_W-1:0] sq;
	} prod_t;

	typedef struct packed {
		logic shift;
		logic add_en;
		logic restart;
		logic hist_ld;
		logic hist_clr;
	} cell_ctl_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_DC,
		ST_Y,
		ST_PROD,
		ST_SHIFT,
		ST_SQR,
		ST_SLICE,
		ST_EMIT
	} state_t;

	localparam logic [1:0] REG_SYNC  = 2'd0;
	localparam logic [1:0] REG_SHIFT = 2'd1;

	localparam logic [15:0] SYNC_RST  = 16'h6868;
	localparam logic [3:0]  SHIFT_RST = 4'd9;

	// 1200 Hz cosine at 19.2 kHz, Q1.15
	function automatic logic signed [15:0] tone_cos(input logic [3:0] idx);
		logic signed [15:0] c;
		unique case (idx)
			4'd0:  c = 16'sd32767;
			4'd1:  c = 16'sd30274;
			4'd2:  c = 16'sd23170;
			4'd3:  c = 16'sd12540;
			4'd4:  c = 16'sd0;
			4'd5:  c = -16'sd12540;
			4'd6:  c = -16'sd23170;
			4'd7:  c = -16'sd30274;
			4'd8:  c = -16'sd32768;
			4'd9:  c = -16'sd30274;
			4'd10: c = -16'sd23170;
			4'd11: c = -16'sd12540;
			4'd12: c = 16'sd0;
			4'd13: c = 16'sd12540;
			4'd14: c = 16'sd23170;
			default: c = 16'sd30274;
		endcase
		return c;
	endfunction

	function automatic logic signed [15:0] tone_sin(input logic [3:0] idx);
		return tone_cos(idx - 4'd4);
	endfunction

endpackage

FILE: src/fsk_bit_demodulator_with_sync_lock.sv
// A bit is registered after its sample passes the DC, Y, PROD, SHIFT, SQR and SLICE states.
// A new sample is taken only in IDLE, after every phase of the previous one is done;
// a lock adds a replay of the 16 sync bits, one bit per cycle while taken.
// The phase ring rotates one cell per PROD and SHIFT pass through a shared MAC stage.
// Reset: sums, histories, DC level and lock cleared; sync_word 0x6868, dc_shift 9.
// ----------------------------------------------------------------------------
// FSK bit demodulator with sync lock
// DC removal, ring of per-phase I/Q correlator cells, slicer and sync search.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module fsk_bit_demodulator_with_sync_lock
	import fskd_pkg::*;
#(
	parameter int SAMPLES_PER_BIT = 8
)
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic signed [15:0] sample,
	output logic        out_valid,
	input  logic        out_ready,
	output logic        bit_res,
	output logic        is_sync,
	output logic        last
);

	localparam int PW = (SAMPLES_PER_BIT > 1) ? $clog2(SAMPLES_PER_BIT) : 1;
	localparam logic [PW-1:0] KLAST = PW'(SAMPLES_PER_BIT - 1);
	localparam logic [PW:0]   NSPB  = (PW+1)'(SAMPLES_PER_BIT);

	state_t state_q, state_d;

	logic [15:0]  sync_q;
	logic [3:0]   shift_q;
	logic signed [15:0] x_q;
	logic signed [27:0] dc_q;
	logic signed [16:0] y_q;
	logic [PW-1:0] pos_q, ph_q, lidx_q;
	logic          locked_q;
	prod_t         prod_q;
	logic          restart_q, close_q, act_q;
	logic signed [41:0] sqmi_q, sqmq_q, sqsi_q, sqsq_q;
	logic [HIST_W-1:0] rep_q;
	logic [3:0]    rep_cnt_q;
	logic          ov_q, bit_q, sync_o_q, last_q;

	cell_t     cd   [SAMPLES_PER_BIT];
	cell_ctl_t ctl  [SAMPLES_PER_BIT];
	cell_t     tail;

	logic wr;
	logic signed [28:0] dc_diff, dc_step;
	logic [PW:0]   kd;
	logic [PW-1:0] k;
	logic [3:0]    km, ks;
	logic          mbit, match, out_free, adv, ow;
	logic [HIST_W-1:0] hnew;
	logic signed [42:0] me, se;
	logic          do_shift, do_ld, do_clr;

	// configuration port
	assign pready = 1'b1;
	assign wr     = psel & penable & pwrite;

	always_comb begin
		prdata = '0;
		if (paddr[2] == REG_SHIFT[0])
			prdata[3:0] = shift_q;
		else
			prdata[15:0] = sync_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sync_q  <= SYNC_RST;
			shift_q <= SHIFT_RST;
		end else if (wr) begin
			if (paddr[2] == REG_SHIFT[0])
				shift_q <= pwdata[3:0];
			else
				sync_q <= pwdata[15:0];
		end
	end

	// datapath helpers
	assign dc_diff = {x_q[15], x_q, 12'b0} - {dc_q[27], dc_q};
	assign dc_step = dc_diff >>> shift_q;

	always_comb begin
		if (pos_q >= ph_q)
			kd = {1'b0, pos_q} - {1'b0, ph_q};
		else
			kd = {1'b0, pos_q} + NSPB - {1'b0, ph_q};
		k  = kd[PW-1:0];
		km = 4'(k);
		ks = {km[2:0], 1'b0};
	end

	assign tail = cd[SAMPLES_PER_BIT-1];
	assign me   = 43'(sqmi_q) + 43'(sqmq_q);
	assign se   = 43'(sqsi_q) + 43'(sqsq_q);
	assign mbit = (me > se);
	assign hnew = {tail.hist[HIST_W-2:0], mbit};
	assign match = (hnew == sync_q) || (~hnew == sync_q);
	assign out_free = !ov_q || out_ready;

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE:  if (in_valid) state_d = ST_DC;
			ST_DC:    state_d = ST_Y;
			ST_Y:     state_d = ST_PROD;
			ST_PROD:  state_d = ST_SHIFT;
			ST_SHIFT: begin
				if (act_q && close_q)
					state_d = ST_SQR;
				else
					state_d = (ph_q == KLAST) ? ST_IDLE : ST_PROD;
			end
			ST_SQR:   state_d = ST_SLICE;
			ST_SLICE: begin
				if (!locked_q && match)
					state_d = ST_EMIT;
				else if (!locked_q || out_free)
					state_d = (ph_q == KLAST) ? ST_IDLE : ST_PROD;
			end
			ST_EMIT: begin
				if (out_free && rep_cnt_q == 4'd15)
					state_d = (ph_q == KLAST) ? ST_IDLE : ST_PROD;
			end
			default:  state_d = ST_IDLE;
		endcase
	end

	// control outputs
	always_comb begin
		in_ready = 1'b0;
		adv      = 1'b0;
		ow       = 1'b0;
		do_shift = 1'b0;
		do_ld    = 1'b0;
		do_clr   = 1'b0;
		unique case (state_q)
			ST_IDLE:  in_ready = 1'b1;
			ST_SHIFT: begin
				do_shift = 1'b1;
				adv      = !(act_q && close_q);
			end
			ST_SLICE: begin
				if (locked_q) begin
					ow  = out_free;
					adv = out_free;
				end else begin
					do_ld  = 1'b1;
					do_clr = match;
					adv    = !match;
				end
			end
			ST_EMIT: begin
				ow  = out_free;
				adv = out_free && (rep_cnt_q == 4'd15);
			end
			default: ;
		endcase
	end

	// sequencer and datapath registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			dc_q      <= '0;
			pos_q     <= '0;
			ph_q      <= '0;
			lidx_q    <= '0;
			locked_q  <= 1'b0;
			rep_cnt_q <= '0;
			ov_q      <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_DC)
				dc_q <= dc_q + 28'(dc_step);
			if (state_q == ST_Y)
				ph_q <= '0;
			if (adv) begin
				if (ph_q == KLAST) begin
					ph_q  <= '0;
					pos_q <= (pos_q == KLAST) ? '0 : pos_q + 1'b1;
				end else begin
					ph_q <= ph_q + 1'b1;
				end
			end
			if (do_clr) begin
				locked_q  <= 1'b1;
				lidx_q    <= ph_q;
				rep_cnt_q <= '0;
			end else if (state_q == ST_EMIT && out_free) begin
				rep_cnt_q <= rep_cnt_q + 1'b1;
			end
			if (ow)
				ov_q <= 1'b1;
			else if (out_ready)
				ov_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready)
			x_q <= sample;
		if (state_q == ST_Y)
			y_q <= 17'(x_q) - 17'($signed(dc_q[27:12]));
		if (state_q == ST_PROD) begin
			prod_q.mi <= PROD_W'(y_q * tone_cos(km));
			prod_q.mq <= PROD_W'(y_q * tone_sin(km));
			prod_q.si <= PROD_W'(y_q * tone_cos(ks));
			prod_q.sq <= PROD_W'(y_q * tone_sin(ks));
			restart_q <= (k == '0);
			close_q   <= (k == KLAST);
			act_q     <= !locked_q || (ph_q == lidx_q);
		end
		if (state_q == ST_SQR) begin
			sqmi_q <= $signed(tail.mi[35:15]) * $signed(tail.mi[35:15]);
			sqmq_q <= $signed(tail.mq[35:15]) * $signed(tail.mq[35:15]);
			sqsi_q <= $signed(tail.si[35:15]) * $signed(tail.si[35:15]);
			sqsq_q <= $signed(tail.sq[35:15]) * $signed(tail.sq[35:15]);
		end
		if (do_clr)
			rep_q <= hnew;
		else if (state_q == ST_EMIT && out_free)
			rep_q <= {rep_q[HIST_W-2:0], 1'b0};
		if (ow) begin
			if (state_q == ST_EMIT) begin
				bit_q    <= rep_q[HIST_W-1];
				sync_o_q <= 1'b1;
				last_q   <= (rep_cnt_q == 4'd15);
			end else begin
				bit_q    <= mbit;
				sync_o_q <= 1'b0;
				last_q   <= 1'b1;
			end
		end
	end

	assign out_valid = ov_q;
	assign bit_res   = bit_q;
	assign is_sync   = sync_o_q;
	assign last      = last_q;

	// ring of phase cells
	for (genvar i = 0; i < SAMPLES_PER_BIT; i++) begin : g_cell
		localparam bit IS_TAIL = (i == SAMPLES_PER_BIT - 1);
		cell_t nb;

		if (IS_TAIL) begin : g_wrap
			assign nb = cd[0];
		end else begin : g_link
			assign nb = cd[i+1];
		end

		assign ctl[i].shift    = do_shift;
		assign ctl[i].add_en   = IS_TAIL && act_q;
		assign ctl[i].restart  = restart_q;
		assign ctl[i].hist_ld  = IS_TAIL && do_ld;
		assign ctl[i].hist_clr = !IS_TAIL && do_clr;

		fskd_cell u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.ctl      (ctl[i]),
			.prod     (prod_q),
			.hist_val (hnew),
			.nb       (nb),
			.data     (cd[i])
		);
	end

	`ASSERT_NEXT(a_lock_sticky, locked_q, locked_q, "lock dropped")
	`ASSERT_NOW(a_emit_locked, state_q == ST_EMIT, locked_q, "sync replay while searching")
	`ASSERT_NOW(a_phase_range, state_q == ST_PROD, ph_q <= KLAST, "phase index out of range")
	`ASSERT_NEXT(a_out_write, ow, ov_q, "result not registered")

endmodule

FILE: src/fskd_cell.sv
// ----------------------------------------------------------------------------
// FSK demodulator phase cell
// Holds one bit phase's correlator sums and history; takes its neighbor's
// contents on a shift, optionally adding fresh products on the way in.
// ----------------------------------------------------------------------------
module fskd_cell
	import fskd_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  cell_ctl_t   ctl,
	input  prod_t       prod,
	input  logic [HIST_W-1:0] hist_val,
	input  cell_t       nb,
	output cell_t       data
);

	cell_t data_q;
	cell_t base;
	cell_t data_d;

	always_comb begin
		base = nb;
		if (ctl.restart) begin
			base.mi = '0;
			base.mq = '0;
			base.si = '0;
			base.sq = '0;
		end
	end

	always_comb begin
		data_d = data_q;
		if (ctl.shift) begin
			data_d = nb;
			if (ctl.add_en) begin
				data_d.mi = base.mi + SUM_W'(prod.mi);
				data_d.mq = base.mq + SUM_W'(prod.mq);
				data_d.si = base.si + SUM_W'(prod.si);
				data_d.sq = base.sq + SUM_W'(prod.sq);
			end
		end
		if (ctl.hist_clr) begin
			data_d.hist = '0;
		end else if (ctl.hist_ld) begin
			data_d.hist = hist_val;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			data_q <= '0;
		end else begin
			data_q <= data_d;
		end
	end

	assign data = data_q;

endmodule
